@@ src/ipv4_address_classifier_top_macros.svh @@
// ----------------------------------------------------------------------------
// ipv4_address_classifier_top_macros
// assertion macros shared by the classifier checker
// ----------------------------------------------------------------------------
`ifndef IPV4_ADDRESS_CLASSIFIER_TOP_MACROS_SVH
`define IPV4_ADDRESS_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define IAC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define IAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/iac_pkg.sv @@
// ----------------------------------------------------------------------------
// iac_pkg
// beat types and codes of the ipv4 address classifier
// ----------------------------------------------------------------------------
package iac_pkg;

  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [2:0] FLD_VALID      = 3'd0;
  localparam logic [2:0] FLD_IFACE      = 3'd1;
  localparam logic [2:0] FLD_NET        = 3'd2;
  localparam logic [2:0] FLD_NETMASK    = 3'd3;
  localparam logic [2:0] FLD_SUBNET     = 3'd4;
  localparam logic [2:0] FLD_SUBNETMASK = 3'd5;
  localparam logic [2:0] FLD_BCAST      = 3'd6;
  localparam logic [2:0] FLD_NETBCAST   = 3'd7;

  localparam logic [7:0] LOOPBACK_NET = 8'h7f;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  entry_index;
    logic [2:0]  field_select;
    logic [31:0] write_value;
    logic [31:0] address;
    logic [2:0]  iface_id;
    logic        iface_can_broadcast;
  } in_t;

  typedef struct packed {
    logic [31:0] net_number;
    logic        is_local;
    logic        can_forward;
    logic        is_broadcast;
  } out_t;

endpackage

@@ src/ipv4_address_classifier_top.sv @@
// ----------------------------------------------------------------------------
// ipv4_address_classifier_top
// classful ipv4 address classifier over a small interface address table
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall / in_data) carries write and classify
//   beats; output channel (out_valid / out_stall / out_data) carries one
//   result beat per classify beat. cfg_we / cfg_wdata set subnets_are_local.
//   a write beat updates one table field in the cycle it is accepted and
//   gives no result; the next beat may follow in the next cycle.
//   a classify beat walks the table one entry per cycle through one shared
//   compare unit over D = min(MAX_ENTRIES, 8) entries, then moves to a
//   finish state that loads the result into the output register. in_stall
//   is high for the whole walk and the finish state, so the next beat is
//   taken only once the result is loaded.
//   results sit in an output register; while the receiver stalls the result
//   holds and a finished walk waits in its finish state.
//   reset clears all entry valid bits, sets subnets_are_local to 1 and
//   empties the output register; other table fields are undefined until
//   written.
// ----------------------------------------------------------------------------
module ipv4_address_classifier_top
  import iac_pkg::*;
#(
  parameter int MAX_ENTRIES = 8,
  parameter int MAX_IFACES  = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  localparam int DEPTH = (MAX_ENTRIES < 8) ? MAX_ENTRIES : 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [3:0] DEPTH_4 = 4'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic             subnets_are_local;
  logic [1:0]       state;
  logic [IDX_W-1:0] cnt;

  logic [DEPTH-1:0] entry_valid;
  logic [2:0]       entry_iface      [DEPTH];
  logic [31:0]      entry_net        [DEPTH];
  logic [31:0]      entry_netmask    [DEPTH];
  logic [31:0]      entry_subnet     [DEPTH];
  logic [31:0]      entry_subnetmask [DEPTH];
  logic [31:0]      entry_bcast      [DEPTH];
  logic [31:0]      entry_netbcast   [DEPTH];

  // item registers
  logic [31:0] addr;
  logic [2:0]  iface;
  logic        bc_ok;
  logic [31:0] class_net;
  logic        class_ok;
  logic        num_hit;
  logic [31:0] num_val;
  logic        loc_hit;
  logic        bc_hit;

  logic        in_acc;
  logic [31:0] cn_comb;
  logic        cn_ok_comb;
  logic        ent_v;
  logic        step_num;
  logic        step_loc;
  logic        step_bc;
  logic        fwd;
  logic        out_free;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // classful net of the incoming address
  always_comb begin
    cn_comb    = 32'd0;
    cn_ok_comb = 1'b1;
    priority casez (in_data.address[31:28])
      4'b0???: cn_comb = {in_data.address[31:24], 24'd0};
      4'b10??: cn_comb = {in_data.address[31:16], 16'd0};
      4'b110?: cn_comb = {in_data.address[31:8], 8'd0};
      4'b1110: cn_comb = {in_data.address[31:28], 28'd0};
      default: cn_ok_comb = 1'b0;
    endcase
  end

  // shared compare unit on the entry under the scan counter
  always_comb begin
    ent_v    = entry_valid[cnt];
    step_num = ent_v && (entry_net[cnt] == class_net);
    if (subnets_are_local) begin
      step_loc = ent_v && ((addr & entry_netmask[cnt]) == entry_net[cnt]);
    end else begin
      step_loc = ent_v && ((addr & entry_subnetmask[cnt]) == entry_subnet[cnt]);
    end
    step_bc = ent_v && bc_ok && (entry_iface[cnt] == iface) &&
              ((addr == entry_bcast[cnt]) || (addr == entry_netbcast[cnt]) ||
               (addr == entry_subnet[cnt]) || (addr == entry_net[cnt]));
  end

  always_comb begin
    fwd = 1'b1;
    if ((addr[31:28] == 4'hf) || (addr[31:28] == 4'he)) begin
      fwd = 1'b0;
    end else if (!addr[31] && ((addr[31:24] == 8'd0) || (addr[31:24] == LOOPBACK_NET))) begin
      fwd = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      subnets_are_local <= 1'b1;
    end else if (cfg_we) begin
      subnets_are_local <= cfg_wdata;
    end
  end

  // table write port
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (in_acc && (in_data.opcode == OP_WRITE) &&
                 ({1'b0, in_data.entry_index} < DEPTH_4)) begin
      unique case (in_data.field_select)
        FLD_VALID:      entry_valid[in_data.entry_index[IDX_W-1:0]] <= in_data.write_value[0];
        FLD_IFACE:      entry_iface[in_data.entry_index[IDX_W-1:0]] <= in_data.write_value[2:0];
        FLD_NET:        entry_net[in_data.entry_index[IDX_W-1:0]] <= in_data.write_value;
        FLD_NETMASK:    entry_netmask[in_data.entry_index[IDX_W-1:0]] <= in_data.write_value;
        FLD_SUBNET:     entry_subnet[in_data.entry_index[IDX_W-1:0]] <= in_data.write_value;
        FLD_SUBNETMASK: entry_subnetmask[in_data.entry_index[IDX_W-1:0]] <= in_data.write_value;
        FLD_BCAST:      entry_bcast[in_data.entry_index[IDX_W-1:0]] <= in_data.write_value;
        FLD_NETBCAST:   entry_netbcast[in_data.entry_index[IDX_W-1:0]] <= in_data.write_value;
        default:        entry_netbcast[in_data.entry_index[IDX_W-1:0]] <= in_data.write_value;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (in_data.opcode == OP_CLASSIFY)) begin
            state <= ST_SCAN;
            cnt   <= '0;
          end
        end
        ST_SCAN: begin
          if (cnt == LAST_IDX) begin
            state <= ST_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.opcode == OP_CLASSIFY)) begin
      addr      <= in_data.address;
      iface     <= in_data.iface_id;
      bc_ok     <= in_data.iface_can_broadcast && ({29'd0, in_data.iface_id} < MAX_IFACES);
      class_net <= cn_comb;
      class_ok  <= cn_ok_comb;
      num_hit   <= 1'b0;
      num_val   <= 32'd0;
      loc_hit   <= 1'b0;
      bc_hit    <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (step_num && !num_hit) begin
        num_hit <= 1'b1;
        num_val <= addr & entry_subnetmask[cnt];
      end
      loc_hit <= loc_hit || step_loc;
      bc_hit  <= bc_hit || step_bc;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      out_data.net_number   <= !class_ok ? 32'd0 : (num_hit ? num_val : class_net);
      out_data.is_local     <= loc_hit;
      out_data.can_forward  <= fwd;
      out_data.is_broadcast <= (addr == 32'hffff_ffff) || (addr == 32'd0) || bc_hit;
    end
  end

endmodule

@@ src/iac_checker.sv @@
// ----------------------------------------------------------------------------
// iac_checker
// port-level checks of the ipv4 address classifier
// ----------------------------------------------------------------------------
`include "ipv4_address_classifier_top_macros.svh"

module iac_checker
  import iac_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data,
  input logic cfg_we,
  input logic cfg_wdata
);

  logic cls_acc;
  logic wr_acc;
  logic cfg_seen;

  assign cls_acc  = in_valid && !in_stall && (in_data.opcode == OP_CLASSIFY);
  assign wr_acc   = in_valid && !in_stall && (in_data.opcode == OP_WRITE);
  assign cfg_seen = cfg_we && cfg_wdata;

  `IAC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(out_data), "stalled result beat changed")
  `IAC_ASSERT_NEXT(a_busy_after_classify, clk, rst, cls_acc || (cfg_seen && cls_acc),
    in_stall, "input not stalled while a classify beat is at work")
  `IAC_ASSERT_NEXT(a_write_no_result, clk, rst, wr_acc && !out_valid,
    !out_valid, "write beat produced a result beat")
  `IAC_ASSERT_SAME(a_result_after_walk, clk, rst, $rose(out_valid),
    $past(in_stall), "result beat without a preceding table walk")

endmodule

bind ipv4_address_classifier_top iac_checker u_iac_checker (.*);

@@ dv/iac_classify_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_classify_checker
// watches both channels and the register port of the address classifier,
// mirrors the interface table, predicts each classification and compares the
// result beats in order, field by field
// ----------------------------------------------------------------------------
module iac_classify_checker
  import iac_pkg::*;
#(
  parameter int MAX_ENTRIES = 8,
  parameter int MAX_IFACES  = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   pending_results,
  output int   mismatch_count
);

  logic        subnets_local;
  logic        tbl_valid      [MAX_ENTRIES];
  logic [2:0]  tbl_iface      [MAX_ENTRIES];
  logic [31:0] tbl_net        [MAX_ENTRIES];
  logic [31:0] tbl_netmask    [MAX_ENTRIES];
  logic [31:0] tbl_subnet     [MAX_ENTRIES];
  logic [31:0] tbl_subnetmask [MAX_ENTRIES];
  logic [31:0] tbl_bcast      [MAX_ENTRIES];
  logic [31:0] tbl_netbcast   [MAX_ENTRIES];

  out_t expected_results[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 100) begin
      $display("%t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic out_t predict_classification(input logic [31:0] a,
                                                  input logic [2:0] ifc,
                                                  input logic cb);
    out_t        r;
    logic [31:0] cnet;
    bit          class_e;
    bit          found;
    r       = '0;
    class_e = 1'b0;
    found   = 1'b0;
    if (!a[31]) begin
      cnet = a & 32'hff00_0000;
    end else if (a[31:30] == 2'b10) begin
      cnet = a & 32'hffff_0000;
    end else if (a[31:29] == 3'b110) begin
      cnet = a & 32'hffff_ff00;
    end else if (a[31:28] == 4'b1110) begin
      cnet = a & 32'hf000_0000;
    end else begin
      cnet    = '0;
      class_e = 1'b1;
    end
    r.net_number = cnet;
    if (!class_e) begin
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        if (!found && tbl_valid[k] && tbl_net[k] == cnet) begin
          r.net_number = a & tbl_subnetmask[k];
          found        = 1'b1;
        end
      end
    end
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (tbl_valid[k]) begin
        if (subnets_local ? ((a & tbl_netmask[k]) == tbl_net[k])
                          : ((a & tbl_subnetmask[k]) == tbl_subnet[k])) begin
          r.is_local = 1'b1;
        end
      end
    end
    r.can_forward = 1'b1;
    if (a[31:28] == 4'hf || a[31:28] == 4'he) begin
      r.can_forward = 1'b0;
    end
    if (!a[31] && (a[31:24] == 8'h00 || a[31:24] == LOOPBACK_NET)) begin
      r.can_forward = 1'b0;
    end
    if (a == 32'hffff_ffff || a == 32'h0) begin
      r.is_broadcast = 1'b1;
    end else if (cb && int'(ifc) < MAX_IFACES) begin
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        if (tbl_valid[k] && tbl_iface[k] == ifc &&
            (a == tbl_bcast[k] || a == tbl_netbcast[k] ||
             a == tbl_subnet[k] || a == tbl_net[k])) begin
          r.is_broadcast = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      subnets_local = 1'b1;
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        tbl_valid[k]      = 1'b0;
        tbl_iface[k]      = '0;
        tbl_net[k]        = '0;
        tbl_netmask[k]    = '0;
        tbl_subnet[k]     = '0;
        tbl_subnetmask[k] = '0;
        tbl_bcast[k]      = '0;
        tbl_netbcast[k]   = '0;
      end
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        subnets_local = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", out_data.net_number, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.net_number !== want.net_number) begin
            report_mismatch("net_number", out_data.net_number, want.net_number);
          end
          if (out_data.is_local !== want.is_local) begin
            report_mismatch("is_local", 32'(out_data.is_local), 32'(want.is_local));
          end
          if (out_data.can_forward !== want.can_forward) begin
            report_mismatch("can_forward", 32'(out_data.can_forward),
                            32'(want.can_forward));
          end
          if (out_data.is_broadcast !== want.is_broadcast) begin
            report_mismatch("is_broadcast", 32'(out_data.is_broadcast),
                            32'(want.is_broadcast));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.opcode == OP_CLASSIFY) begin
          expected_results.push_back(predict_classification(in_data.address,
              in_data.iface_id, in_data.iface_can_broadcast));
        end else if (int'(in_data.entry_index) < MAX_ENTRIES) begin
          case (in_data.field_select)
            FLD_VALID:      tbl_valid[in_data.entry_index]      = in_data.write_value[0];
            FLD_IFACE:      tbl_iface[in_data.entry_index]      = in_data.write_value[2:0];
            FLD_NET:        tbl_net[in_data.entry_index]        = in_data.write_value;
            FLD_NETMASK:    tbl_netmask[in_data.entry_index]    = in_data.write_value;
            FLD_SUBNET:     tbl_subnet[in_data.entry_index]     = in_data.write_value;
            FLD_SUBNETMASK: tbl_subnetmask[in_data.entry_index] = in_data.write_value;
            FLD_BCAST:      tbl_bcast[in_data.entry_index]      = in_data.write_value;
            default:        tbl_netbcast[in_data.entry_index]   = in_data.write_value;
          endcase
        end
      end
    end
    pending_results = expected_results.size();
  end

endmodule

@@ dv/tb_ipv4_address_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_address_classifier_top
// loads the interface table, runs directed and random classifications under
// bursty input and a varying output stall, toggling subnets_are_local
// between phases; a side checker predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb_ipv4_address_classifier_top;
  import iac_pkg::*;

  localparam int RANDOM_ITEMS   = 1050;
  localparam int PHASE_ITEMS    = 150;
  localparam int IDLE_LIMIT     = 2000;
  localparam int SETTLE_CYCLES  = 12;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic cfg_wdata;
  int   pending_results;
  int   mismatch_count;

  int          burst_left;
  int          n_write;
  int          n_classify;
  int          n_cfg;
  logic [7:0]  written     [8];
  logic [2:0]  sh_iface    [8];
  logic [31:0] sh_net      [8];
  logic [31:0] sh_netmask  [8];
  logic [31:0] sh_subnet   [8];
  logic [31:0] sh_smask    [8];
  logic [31:0] sh_bcast    [8];
  logic [31:0] sh_netbcast [8];

  ipv4_address_classifier_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  iac_classify_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    int mode;
    int left;
    int tick;
    out_stall = 1'b0;
    mode      = 0;
    left      = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(30, 200);
      end
      left--;
      tick++;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((tick % 7) < 3);
      endcase
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_beat(input in_t beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (beat.opcode == OP_CLASSIFY) begin
      n_classify++;
    end else begin
      n_write++;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic set_subnets_are_local(input logic v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'($urandom_range(0, 1));
    n_cfg++;
  endtask

  task automatic write_field(input logic [2:0] e, input logic [2:0] f,
                             input logic [31:0] v);
    in_t b;
    b.opcode              = OP_WRITE;
    b.entry_index         = e;
    b.field_select        = f;
    b.write_value         = v;
    b.address             = $urandom;
    b.iface_id            = 3'($urandom_range(0, 7));
    b.iface_can_broadcast = 1'($urandom_range(0, 1));
    case (f)
      FLD_VALID: begin
        if ((written[e] | 8'h01) != 8'hff) begin
          b.write_value[0] = 1'b0;
        end
      end
      FLD_IFACE:      sh_iface[e]    = v[2:0];
      FLD_NET:        sh_net[e]      = v;
      FLD_NETMASK:    sh_netmask[e]  = v;
      FLD_SUBNET:     sh_subnet[e]   = v;
      FLD_SUBNETMASK: sh_smask[e]    = v;
      FLD_BCAST:      sh_bcast[e]    = v;
      default:        sh_netbcast[e] = v;
    endcase
    if (f != FLD_VALID) begin
      written[e][f] = 1'b1;
    end
    send_beat(b);
  endtask

  task automatic classify(input logic [31:0] a, input logic [2:0] ifc,
                          input logic cb);
    in_t b;
    b.opcode              = OP_CLASSIFY;
    b.entry_index         = 3'($urandom_range(0, 7));
    b.field_select        = 3'($urandom_range(0, 7));
    b.write_value         = $urandom;
    b.address             = a;
    b.iface_id            = ifc;
    b.iface_can_broadcast = cb;
    send_beat(b);
  endtask

  task automatic program_entry(input logic [2:0] e, input logic enable);
    logic [31:0] r;
    logic [31:0] net;
    logic [31:0] nmask;
    logic [31:0] smask;
    logic [31:0] sub;
    int          mlen;
    int          plen;
    r = $urandom;
    case ($urandom_range(0, 2))
      0: begin
        net  = {1'b0, r[6:0], 24'h0};
        mlen = 8;
      end
      1: begin
        net  = {2'b10, r[13:0], 16'h0};
        mlen = 16;
      end
      default: begin
        net  = {3'b110, r[20:0], 8'h0};
        mlen = 24;
      end
    endcase
    nmask = 32'hffff_ffff << (32 - mlen);
    plen  = $urandom_range(mlen, 30);
    smask = 32'hffff_ffff << (32 - plen);
    sub   = (net | $urandom) & smask;
    r     = $urandom;
    write_field(e, FLD_IFACE, r);
    write_field(e, FLD_NET, net);
    write_field(e, FLD_NETMASK, nmask);
    write_field(e, FLD_SUBNET, sub);
    write_field(e, FLD_SUBNETMASK, smask);
    write_field(e, FLD_BCAST, sub | ~smask);
    write_field(e, FLD_NETBCAST, net | ~nmask);
    r = $urandom;
    write_field(e, FLD_VALID, {r[31:1], enable});
  endtask

  function automatic logic [31:0] pick_address(input logic [2:0] e);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1: return r;
      2:    return sh_subnet[e] | (r & ~sh_smask[e]);
      3:    return sh_net[e] | (r & ~sh_netmask[e]);
      4:    return sh_bcast[e];
      5:    return sh_netbcast[e];
      6:    return sh_subnet[e];
      7:    return sh_net[e];
      8: begin
        case ($urandom_range(0, 5))
          0:       return 32'h0;
          1:       return 32'hffff_ffff;
          2:       return {LOOPBACK_NET, r[23:0]};
          3:       return {8'h00, r[23:0]};
          4:       return {4'he, r[27:0]};
          default: return {4'hf, r[27:0]};
        endcase
      end
      default: return sh_net[e] ^ (32'h1 << r[4:0]);
    endcase
  endfunction

  initial begin
    int          rand_items;
    int          next_phase;
    int          sel;
    logic [2:0]  e;
    logic [31:0] r;
    logic        cfg_value;

    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = 1'b0;
    burst_left = 0;
    n_write    = 0;
    n_classify = 0;
    n_cfg      = 0;
    for (int k = 0; k < 8; k++) begin
      written[k]     = '0;
      sh_iface[k]    = '0;
      sh_net[k]      = '0;
      sh_netmask[k]  = '0;
      sh_subnet[k]   = '0;
      sh_smask[k]    = '0;
      sh_bcast[k]    = '0;
      sh_netbcast[k] = '0;
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_subnets_are_local(1'b1);

    // entry 0: class a net with a /16 subnet on interface 0
    write_field(3'd0, FLD_IFACE, 32'hffff_fff8);
    write_field(3'd0, FLD_NET, 32'h0a00_0000);
    write_field(3'd0, FLD_NETMASK, 32'hff00_0000);
    write_field(3'd0, FLD_SUBNET, 32'h0a01_0000);
    write_field(3'd0, FLD_SUBNETMASK, 32'hffff_0000);
    write_field(3'd0, FLD_BCAST, 32'h0a01_ffff);
    write_field(3'd0, FLD_NETBCAST, 32'h0aff_ffff);
    write_field(3'd0, FLD_VALID, 32'hffff_ffff);
    // entry 1: class c net with a /25 subnet on interface 7
    write_field(3'd1, FLD_IFACE, 32'h0000_0007);
    write_field(3'd1, FLD_NET, 32'hc0a8_0100);
    write_field(3'd1, FLD_NETMASK, 32'hffff_ff00);
    write_field(3'd1, FLD_SUBNET, 32'hc0a8_0180);
    write_field(3'd1, FLD_SUBNETMASK, 32'hffff_ff80);
    write_field(3'd1, FLD_BCAST, 32'hc0a8_01ff);
    write_field(3'd1, FLD_NETBCAST, 32'hc0a8_01fe);
    write_field(3'd1, FLD_VALID, 32'h0000_0001);

    classify(32'h0000_0000, 3'd5, 1'b0);
    classify(32'hffff_ffff, 3'd2, 1'b0);
    classify(32'h0a01_0203, 3'd0, 1'b1);
    classify(32'h0a01_ffff, 3'd0, 1'b1);
    classify(32'h0a01_ffff, 3'd7, 1'b1);
    classify(32'h0aff_ffff, 3'd0, 1'b0);
    classify(32'hc0a8_0180, 3'd7, 1'b1);
    classify(32'hc0a8_01fe, 3'd7, 1'b1);
    classify(32'h7f00_0001, 3'd0, 1'b1);
    classify(32'h0012_3456, 3'd0, 1'b1);
    classify(32'hac10_0001, 3'd0, 1'b1);
    classify(32'he000_0001, 3'd0, 1'b1);
    classify(32'hf000_0001, 3'd0, 1'b1);

    set_subnets_are_local(1'b0);
    classify(32'hc0a8_0105, 3'd7, 1'b1);
    classify(32'h0a02_0001, 3'd0, 1'b1);
    write_field(3'd1, FLD_VALID, 32'hffff_fffe);
    classify(32'hc0a8_0185, 3'd7, 1'b1);

    cfg_value  = 1'b0;
    rand_items = 0;
    next_phase = PHASE_ITEMS;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items >= next_phase) begin
        cfg_value = ~cfg_value;
        set_subnets_are_local(cfg_value);
        next_phase += PHASE_ITEMS;
      end
      sel = $urandom_range(0, 99);
      r   = $urandom;
      e   = r[2:0];
      if (sel < 8) begin
        program_entry(e, ($urandom_range(0, 4) != 0));
        rand_items += 8;
      end else if (sel < 16) begin
        write_field(e, r[5:3], $urandom);
        rand_items++;
      end else begin
        classify(pick_address(e),
                 ($urandom_range(0, 3) != 0) ? sh_iface[e] : r[8:6],
                 ($urandom_range(0, 3) != 0));
        rand_items++;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES + 8) @(negedge clk);
    $display("covered %0d table writes and %0d classifications", n_write, n_classify);
    $display("across %0d subnets_are_local writes, both match modes", n_cfg);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/iac_pkg.sv
src/ipv4_address_classifier_top.sv
src/iac_checker.sv
dv/iac_classify_checker.sv
dv/tb_ipv4_address_classifier_top.sv
